@@ design/cbip_pkg.sv @@
// Package for the custom base integer parser.
// Holds payload structs, the parse phase enum, register indexes, reset values and character codes.
// Used by every module of the block; depends on nothing.
package cbip_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] parsed_value;
    logic               base_invalid;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_SKIP  = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_e;

  localparam logic [1:0] CFG_ALPHA_LOW  = 2'd0;
  localparam logic [1:0] CFG_ALPHA_HIGH = 2'd1;
  localparam logic [1:0] CFG_BASE_LEN   = 2'd2;

  localparam logic [63:0] ALPHA_LOW_RST  = 64'd3978425819141910832;
  localparam logic [63:0] ALPHA_HIGH_RST = 64'd14648;
  localparam logic [4:0]  BASE_LEN_RST   = 5'd10;

  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] SKIP_MAX     = 8'd32;

endpackage

@@ design/custom_base_integer_parser.sv @@
// Top level of the custom base integer parser: config registers, input
// register, parse state and result register. Depends on cbip_pkg,
// cbip_digit_lut and cbip_alpha_check.
//
// One byte is taken per transfer and the block sustains one byte per clock,
// except while a final byte waits on the held result register. Each byte is
// held in the input register; the parse step (digit compare, one multiply-add
// by the base, sign and phase update) runs in a single pass from there, and
// the byte that carries end_of_string loads the result register.
// The result register holds while out_stall_i is high; other bytes keep
// flowing, and only a final byte waits for that register to free.
// Configuration is written through the cfg channel, always ready, and must
// only change while no string is in flight.
module custom_base_integer_parser #(
  parameter int MAX_BASE    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cbip_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cbip_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  localparam int IDX_W = $clog2(MAX_BASE);

  logic [63:0] alpha_low_q;
  logic [63:0] alpha_high_q;
  logic [4:0]  base_q;

  logic                 in_valid_q;
  cbip_pkg::in_item_t   in_data_q;
  logic                 out_valid_q;
  cbip_pkg::out_item_t  out_data_q;
  cbip_pkg::out_item_t  out_data_d;

  cbip_pkg::phase_e       phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;

  logic [MAX_BASE*8-1:0]  alpha_flat;
  logic [4:0]             used;
  logic                   dig_found;
  logic [IDX_W-1:0]       dig_index;
  logic                   alpha_ok;
  logic                   out_free;
  logic                   proc;
  logic                   in_xfer;
  logic [VALUE_WIDTH-1:0] value;
  logic signed [63:0]     value_ext;
  logic                   skip_byte;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_low_q  <= cbip_pkg::ALPHA_LOW_RST;
      alpha_high_q <= cbip_pkg::ALPHA_HIGH_RST;
      base_q       <= cbip_pkg::BASE_LEN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cbip_pkg::CFG_ALPHA_LOW:  alpha_low_q  <= cfg_data_i;
        cbip_pkg::CFG_ALPHA_HIGH: alpha_high_q <= cfg_data_i;
        cbip_pkg::CFG_BASE_LEN:   base_q       <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_BASE; k++) begin
      if (k < 8) begin
        alpha_flat[8*k +: 8] = alpha_low_q[8*k +: 8];
      end else begin
        alpha_flat[8*k +: 8] = alpha_high_q[8*(k-8) +: 8];
      end
    end
  end

  assign used = (base_q > 5'(MAX_BASE)) ? 5'(MAX_BASE) : base_q;

  cbip_digit_lut #(
    .MAX_BASE (MAX_BASE),
    .IDX_W    (IDX_W)
  ) u_digit_lut (
    .alpha_i  (alpha_flat),
    .used_i   (used),
    .char_i   (in_data_q.char_byte),
    .found_o  (dig_found),
    .index_o  (dig_index)
  );

  cbip_alpha_check #(
    .MAX_BASE (MAX_BASE)
  ) u_alpha_check (
    .alpha_i  (alpha_flat),
    .base_i   (base_q),
    .used_i   (used),
    .valid_o  (alpha_ok)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && (!in_data_q.end_of_string || out_free);
  assign in_stall_o = in_valid_q && !proc;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign skip_byte  = (in_data_q.char_byte >= 8'd1) &&
                      (in_data_q.char_byte <= cbip_pkg::SKIP_MAX);

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if ((phase_d == cbip_pkg::PH_SKIP) && !skip_byte) begin
      phase_d = cbip_pkg::PH_SIGN;
    end
    if (phase_d == cbip_pkg::PH_SIGN) begin
      if (in_data_q.char_byte == cbip_pkg::CH_MINUS) begin
        neg_d = !neg_d;
      end else if (in_data_q.char_byte != cbip_pkg::CH_PLUS) begin
        phase_d = cbip_pkg::PH_DIGIT;
      end
    end
    if (phase_d == cbip_pkg::PH_DIGIT) begin
      if (dig_found) begin
        acc_d = VALUE_WIDTH'(acc_q * VALUE_WIDTH'(used)) + VALUE_WIDTH'(dig_index);
      end else begin
        phase_d = cbip_pkg::PH_DONE;
      end
    end

    value     = neg_d ? (VALUE_WIDTH'(0) - acc_d) : acc_d;
    value_ext = 64'(signed'(value));
    out_data_d.parsed_value = alpha_ok ? value_ext[31:0] : 32'sd0;
    out_data_d.base_invalid = !alpha_ok;

    if (in_data_q.end_of_string) begin
      phase_d = cbip_pkg::PH_SKIP;
      neg_d   = 1'b0;
      acc_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= cbip_pkg::PH_SKIP;
      neg_q       <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc) begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
      end
      if (proc && in_data_q.end_of_string) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_data_q <= in_data_i;
    end
    if (proc && in_data_q.end_of_string) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ design/cbip_digit_lut.sv @@
// Digit lookup: compares one byte against the characters in use.
// Returns the lowest matching index. Depends on cbip_pkg.
module cbip_digit_lut #(
  parameter int MAX_BASE = 16,
  parameter int IDX_W    = 4
) (
  input  logic [MAX_BASE*8-1:0] alpha_i,
  input  logic [4:0]            used_i,
  input  logic [7:0]            char_i,
  output logic                  found_o,
  output logic [IDX_W-1:0]      index_o
);

  always_comb begin
    found_o = 1'b0;
    index_o = '0;
    for (int i = MAX_BASE - 1; i >= 0; i--) begin
      if ((5'(i) < used_i) && (alpha_i[8*i +: 8] == char_i) && (char_i != cbip_pkg::CH_NUL)) begin
        found_o = 1'b1;
        index_o = IDX_W'(i);
      end
    end
  end

endmodule

@@ design/cbip_alpha_check.sv @@
// Alphabet check: base range, forbidden characters and pairwise duplicates.
// Pure function of the configuration registers. Depends on cbip_pkg.
module cbip_alpha_check #(
  parameter int MAX_BASE = 16
) (
  input  logic [MAX_BASE*8-1:0] alpha_i,
  input  logic [4:0]            base_i,
  input  logic [4:0]            used_i,
  output logic                  valid_o
);

  logic bad_char;
  logic dup_char;

  always_comb begin
    bad_char = 1'b0;
    dup_char = 1'b0;
    for (int i = 0; i < MAX_BASE; i++) begin
      if (5'(i) < used_i) begin
        if ((alpha_i[8*i +: 8] == cbip_pkg::CH_NUL) ||
            (alpha_i[8*i +: 8] == cbip_pkg::CH_PLUS) ||
            (alpha_i[8*i +: 8] == cbip_pkg::CH_MINUS)) begin
          bad_char = 1'b1;
        end
        for (int j = i + 1; j < MAX_BASE; j++) begin
          if ((5'(j) < used_i) && (alpha_i[8*j +: 8] == alpha_i[8*i +: 8])) begin
            dup_char = 1'b1;
          end
        end
      end
    end
    valid_o = (base_i >= 5'd2) && (base_i <= 5'(MAX_BASE)) && !bad_char && !dup_char;
  end

endmodule

@@ verif/cbip_parse_checker.sv @@
// Checker for the custom base integer parser: watches the config, input and result channels.
// Keeps its own copy of the alphabet registers and the parse state, and predicts each value.
// Checks every result in order; exports fail, pending, value, invalid counts. Uses cbip_pkg.
module cbip_parse_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  cbip_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  cbip_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  values_o,
  output int                  invalid_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BASE = 16;

  logic [63:0]         alpha_lo;
  logic [63:0]         alpha_hi;
  logic [4:0]          radix_len;
  cbip_pkg::phase_e    phase;
  logic                neg;
  logic [31:0]         acc;
  cbip_pkg::out_item_t value_q[$];
  int                  fail_count = 0;
  int                  values = 0;
  int                  invalids = 0;

  assign fail_count_o = fail_count;
  assign values_o     = values;
  assign invalid_o    = invalids;

  function automatic logic [7:0] alpha_char(int k);
    if (k < 8) begin
      return alpha_lo[8*k +: 8];
    end
    return alpha_hi[8*(k-8) +: 8];
  endfunction

  function automatic int used_digits();
    return (radix_len > MAX_BASE) ? MAX_BASE : int'(radix_len);
  endfunction

  function automatic int digit_index(logic [7:0] b);
    int k;
    if (b == cbip_pkg::CH_NUL) return -1;
    for (k = 0; k < used_digits(); k++) begin
      if (alpha_char(k) == b) return k;
    end
    return -1;
  endfunction

  function automatic bit alphabet_ok();
    int i;
    int j;
    logic [7:0] c;
    if (radix_len < 2 || radix_len > MAX_BASE) return 1'b0;
    for (i = 0; i < used_digits(); i++) begin
      c = alpha_char(i);
      if (c == cbip_pkg::CH_NUL || c == cbip_pkg::CH_PLUS || c == cbip_pkg::CH_MINUS)
        return 1'b0;
      for (j = i + 1; j < used_digits(); j++) begin
        if (alpha_char(j) == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    fail_count++;
    if (fail_count <= 50) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic parse_byte(cbip_pkg::in_item_t item);
    logic [7:0] b;
    int d;
    cbip_pkg::out_item_t want;
    b = item.char_byte;
    if (phase == cbip_pkg::PH_SKIP &&
        (b == cbip_pkg::CH_NUL || b > cbip_pkg::SKIP_MAX)) phase = cbip_pkg::PH_SIGN;
    if (phase == cbip_pkg::PH_SIGN) begin
      if (b == cbip_pkg::CH_MINUS) neg = ~neg;
      else if (b != cbip_pkg::CH_PLUS) phase = cbip_pkg::PH_DIGIT;
    end
    if (phase == cbip_pkg::PH_DIGIT) begin
      d = digit_index(b);
      if (d >= 0) acc = acc * 32'(used_digits()) + 32'(d);
      else phase = cbip_pkg::PH_DONE;
    end
    if (item.end_of_string) begin
      want.base_invalid = ~alphabet_ok();
      want.parsed_value = want.base_invalid ? 32'd0 : (neg ? -acc : acc);
      value_q.push_back(want);
      phase = cbip_pkg::PH_SKIP;
      neg   = 1'b0;
      acc   = '0;
    end
  endtask

  task automatic check_value(cbip_pkg::out_item_t got);
    cbip_pkg::out_item_t want;
    if (value_q.size() == 0) begin
      report_mismatch($sformatf("result %0d (invalid %0b) with nothing pending",
                                got.parsed_value, got.base_invalid));
      return;
    end
    want = value_q.pop_front();
    values++;
    if (want.base_invalid) invalids++;
    if (got.parsed_value !== want.parsed_value)
      report_mismatch($sformatf("parsed_value %0d, want %0d", got.parsed_value,
                                want.parsed_value));
    if (got.base_invalid !== want.base_invalid)
      report_mismatch($sformatf("base_invalid %0b, want %0b", got.base_invalid,
                                want.base_invalid));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_lo  = cbip_pkg::ALPHA_LOW_RST;
      alpha_hi  = cbip_pkg::ALPHA_HIGH_RST;
      radix_len = cbip_pkg::BASE_LEN_RST;
      phase     = cbip_pkg::PH_SKIP;
      neg       = 1'b0;
      acc       = '0;
      value_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          cbip_pkg::CFG_ALPHA_LOW:  alpha_lo  = cfg_data_i;
          cbip_pkg::CFG_ALPHA_HIGH: alpha_hi  = cfg_data_i;
          cbip_pkg::CFG_BASE_LEN:   radix_len = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) parse_byte(in_data_i);
      if (out_valid_i && !out_stall_i) check_value(out_data_i);
    end
    pending_o <= value_q.size();
  end

endmodule

@@ verif/custom_base_integer_parser_tb.sv @@
// Testbench top for the custom base integer parser: clock, reset, string stimulus and verdict.
// Walks through many alphabet settings, valid and invalid, with random gaps and output stalls.
// Depends on cbip_pkg, custom_base_integer_parser and cbip_parse_checker.
module custom_base_integer_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT       = 300000;
  localparam int BYTES_PER_SETTING = 115;

  typedef enum int {
    SET_RESET, SET_HEX, SET_BINARY, SET_BASE_ZERO, SET_BASE_ONE, SET_BASE_31,
    SET_BASE_17, SET_PLUS, SET_MINUS, SET_NUL, SET_DUP, SET_ALL_ONES,
    SET_ALL_ZERO, SET_RANDOM
  } setting_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  cbip_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  cbip_pkg::out_item_t out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i = '0;
  logic [63:0]         cfg_data_i  = '0;

  int          fail_count;
  int          pending;
  int          values;
  int          invalids;

  logic [7:0]  tb_alpha [16];
  logic [4:0]  tb_base    = cbip_pkg::BASE_LEN_RST;
  bit          calm       = 1'b0;
  int          stall_left = 0;
  int          stall_draw;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          strings_sent = 0;
  int          settings_run = 0;

  always #4 clk_i = ~clk_i;

  custom_base_integer_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  cbip_parse_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .values_o     (values),
    .invalid_o    (invalids)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, 8);
  endfunction

  // result side: hold stall for a drawn number of cycles after each transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        stall_draw = draw_wait();
        stall_left <= stall_draw;
        out_stall_i <= (stall_draw != 0);
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else begin
        stall_left <= 0;
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] odd_byte();
    case ($urandom_range(0, 7))
      0: return cbip_pkg::CH_NUL;
      1: return cbip_pkg::SKIP_MAX;
      2: return cbip_pkg::CH_PLUS;
      3: return cbip_pkg::CH_MINUS;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, logic eos);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {b, eos};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_seq(logic [7:0] text[$]);
    int k;
    for (k = 0; k < text.size(); k++) send_byte(text[k], k == text.size() - 1);
    strings_sent++;
  endtask

  task automatic send_text(string s);
    logic [7:0] text[$];
    int k;
    for (k = 0; k < s.len(); k++) text.push_back(s[k]);
    send_seq(text);
  endtask

  task automatic send_random_string();
    logic [7:0] text[$];
    int used;
    used = (tb_base > 16) ? 16 : ((tb_base < 1) ? 1 : int'(tb_base));
    if ($urandom_range(0, 9) < 8) begin
      repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0)
        text.push_back(8'($urandom_range(1, 32)));
      repeat ($urandom_range(0, 3))
        text.push_back($urandom_range(0, 1) ? cbip_pkg::CH_MINUS : cbip_pkg::CH_PLUS);
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 6))
        text.push_back(tb_alpha[$urandom_range(0, used - 1)]);
      repeat ($urandom_range(0, 2)) text.push_back(odd_byte());
    end else begin
      repeat ($urandom_range(1, 6)) text.push_back(odd_byte());
    end
    if (text.size() == 0) text.push_back(odd_byte());
    send_seq(text);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic write_config(logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
    int k;
    cfg_write(cbip_pkg::CFG_ALPHA_LOW, lo);
    cfg_write(cbip_pkg::CFG_ALPHA_HIGH, hi);
    cfg_write(cbip_pkg::CFG_BASE_LEN, {$urandom(), 27'($urandom()), len});
    cfg_valid_i <= 1'b0;
    for (k = 0; k < 16; k++) begin
      if (k < 8) tb_alpha[k] = lo[8*k +: 8];
      else tb_alpha[k] = hi[8*(k-8) +: 8];
    end
    tb_base = len;
  endtask

  // distinct nonzero sign-free characters, then one defect as the setting asks
  task automatic random_alphabet(logic [4:0] base, setting_e kind);
    logic [7:0]  ch [16];
    logic [7:0]  c;
    logic [63:0] lo;
    logic [63:0] hi;
    int          k;
    int          j;
    int          n;
    int          pos;
    bit          dup;
    for (k = 0; k < 16; k++) begin
      do begin
        c = 8'($urandom_range(1, 255));
        dup = (c == cbip_pkg::CH_PLUS || c == cbip_pkg::CH_MINUS);
        for (j = 0; j < k; j++) if (ch[j] == c) dup = 1'b1;
      end while (dup);
      ch[k] = c;
    end
    n = (base > 16) ? 16 : int'(base);
    case (kind)
      SET_PLUS:  ch[$urandom_range(0, n - 1)] = cbip_pkg::CH_PLUS;
      SET_MINUS: ch[$urandom_range(0, n - 1)] = cbip_pkg::CH_MINUS;
      SET_NUL:   ch[$urandom_range(0, n - 1)] = cbip_pkg::CH_NUL;
      SET_DUP: begin
        pos = $urandom_range(1, n - 1);
        ch[pos] = ch[$urandom_range(0, pos - 1)];
      end
      default: ;
    endcase
    for (k = 0; k < 16; k++) begin
      if (k < 8) lo[8*k +: 8] = ch[k];
      else hi[8*(k-8) +: 8] = ch[k];
    end
    write_config(lo, hi, base);
  endtask

  task automatic apply_setting(setting_e sel);
    case (sel)
      SET_HEX:       write_config(64'h3736353433323130, 64'h6665646362613938, 5'd16);
      SET_BINARY:    write_config(64'h0000000000003130, '1, 5'd2);
      SET_BASE_ZERO: random_alphabet(5'd0, SET_RANDOM);
      SET_BASE_ONE:  random_alphabet(5'd1, SET_RANDOM);
      SET_BASE_31:   random_alphabet(5'd31, SET_RANDOM);
      SET_BASE_17:   random_alphabet(5'd17, SET_RANDOM);
      SET_PLUS, SET_MINUS, SET_NUL, SET_DUP:
        random_alphabet(5'($urandom_range(2, 16)), sel);
      SET_ALL_ONES:  write_config('1, '1, 5'd16);
      SET_ALL_ZERO:  write_config('0, '0, 5'd2);
      default:       random_alphabet(5'($urandom_range(2, 16)), SET_RANDOM);
    endcase
  endtask

  initial begin
    logic [7:0] text[$];
    int         p;
    int         start_bytes;
    bit         paused;
    setting_e   sel;
    paused = 1'b0;
    tb_alpha = '{8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
                 8'h38, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset alphabet: one-byte string, lone NUL, skip/sign/terminator, high byte, min int
    send_text("7");
    send_byte(cbip_pkg::CH_NUL, 1'b1);
    strings_sent++;
    text = '{8'h20, 8'h01, cbip_pkg::CH_MINUS, cbip_pkg::CH_MINUS, cbip_pkg::CH_MINUS,
             8'h39, 8'h78, 8'h35};
    send_seq(text);
    text = '{8'hFF, 8'h33};
    send_seq(text);
    send_text("-2147483648");

    for (p = 0; p < SET_RANDOM + 3; p++) begin
      sel = (p > SET_RANDOM) ? SET_RANDOM : setting_e'(p);
      calm = (p % 5 == 2);
      if (sel != SET_RESET) begin
        drain();
        apply_setting(sel);
      end
      settings_run++;
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < BYTES_PER_SETTING) begin
        if (sel == SET_BASE_ONE && !paused && bytes_sent - start_bytes > 50) begin
          drain();
          paused = 1'b1;
        end
        send_random_string();
      end
    end

    drain();
    $display("Parsed %0d strings (%0d bytes) across %0d alphabet settings.",
             strings_sent, bytes_sent, settings_run);
    $display("Checked %0d values, %0d of them under an invalid alphabet.", values, invalids);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
